### hw/rtl/dzs_pkg.sv
// shared types and constants of the digitizer zero suppression block
package dzs_pkg;

	// byte lanes in one raw word
	localparam int unsigned LANES = 4;
	localparam int unsigned SAMPLE_W = 8;

	// result queue depth
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// result word kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DESC   = 2'd1;
	localparam logic [1:0] KIND_HDR0   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_WORDS     = 2'd1;
	localparam logic [1:0] CFG_FMT_MASK  = 2'd2;

	// header positions
	localparam logic [2:0] HDR_WORD0 = 3'd0;
	localparam logic [2:0] HDR_WORD1 = 3'd1;
	localparam logic [2:0] HDR_DATA  = 3'd4;

	// top nibble of header word 0 that survives patching
	localparam logic [31:0] HDR0_KEEP_MASK = 32'hF000_0000;

	// per-lane min and max candidates
	typedef struct packed {
		logic [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0] max;
	} lane_t;

	// merged span result of one word
	typedef struct packed {
		logic [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0] max;
		logic                keep;
	} merge_t;

	// one result item
	typedef struct packed {
		logic [31:0] out_word;
		logic [1:0]  word_kind;
		logic [1:0]  header_index;
		logic [2:0]  channel_number;
		logic        keep_channel;
		logic        end_of_event;
	} res_t;

endpackage

### hw/rtl/dzs_lane.sv
// one byte lane: folds its sample into the running minimum and maximum
module dzs_lane
	import dzs_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [SAMPLE_W-1:0] run_min,
	input  logic [SAMPLE_W-1:0] run_max,
	output lane_t               lane
);

	// compare the sample against the running extremes
	always_comb begin
		lane.min = (sample < run_min) ? sample : run_min;
		lane.max = (sample > run_max) ? sample : run_max;
	end

endmodule

### hw/rtl/dzs_merge.sv
// merge of the lane results and peak-to-peak threshold test
module dzs_merge
	import dzs_pkg::*;
(
	input  lane_t [LANES-1:0] lanes,
	input  logic [8:0]        threshold,
	output merge_t            merged
);

	logic [SAMPLE_W-1:0] min01, min23, max01, max23;
	logic [SAMPLE_W-1:0] min_all, max_all;
	logic [8:0]          span;

	// two-level min/max tree over the four lanes, then the span test
	// a threshold above 255 never passes
	always_comb begin
		min01 = (lanes[1].min < lanes[0].min) ? lanes[1].min : lanes[0].min;
		min23 = (lanes[3].min < lanes[2].min) ? lanes[3].min : lanes[2].min;
		max01 = (lanes[1].max > lanes[0].max) ? lanes[1].max : lanes[0].max;
		max23 = (lanes[3].max > lanes[2].max) ? lanes[3].max : lanes[2].max;
		min_all = (min23 < min01) ? min23 : min01;
		max_all = (max23 > max01) ? max23 : max01;
		span = {1'b0, max_all} - {1'b0, min_all};
		merged.min  = min_all;
		merged.max  = max_all;
		merged.keep = (max_all >= min_all) && (span >= threshold);
	end

endmodule

### hw/rtl/dzs_out_queue.sv
// result queue taking up to two results a cycle and giving one
module dzs_out_queue
	import dzs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  res_t              push0,
	input  res_t              push1,
	output logic              room2,
	output logic              head_valid,
	output res_t              head,
	input  logic              pop
);

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop_ok;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign room2      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign pop_ok     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= push1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push_n);
			rd_q  <= rd_q + QPTR_W'(pop_ok);
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop_ok);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room2)
		else $error("results pushed without room for two");

endmodule

### hw/rtl/digitizer_zero_suppression.sv
// top level of the digitizer zero suppression block
//
// Raw event words enter on in_valid/raw_word and are taken when in_stall
// is low: four header words, then CHANNELS channels of words_per_channel
// sample words, four 8-bit samples to a word. Header words 1 to 3 come out
// at once (word 1 with the format mask OR-ed in); word 0 is held back.
// Each channel end gives a descriptor, and the last channel also gives the
// patched header word 0 flagged end_of_event.
// Results are computed combinationally and written into a four-entry result
// queue, and reach the outputs once the results ahead of them have left.
// One raw word per cycle is sustained while in_stall is low; the four byte
// lanes and the min/max merge are combinational. in_stall rises while the
// queue holds more than two results, so a stalled receiver backs pressure
// up to the source with at most four results held. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready. The
// user must see that it is written only between events; the block does not
// enforce this. Reset clears the configuration to threshold 0, one word per
// channel and an empty mask, empties the queue and waits for header word 0.
module digitizer_zero_suppression
	import dzs_pkg::*;
#(
	parameter int unsigned CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] raw_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word,
	output logic [1:0]  word_kind,
	output logic [1:0]  header_index,
	output logic [2:0]  channel_number,
	output logic        keep_channel,
	output logic        end_of_event,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [8:0]          thr_q;
	logic [11:0]         wpc_q;
	logic [31:0]         mask_q;
	logic [2:0]          hdr_pos_q;
	logic [2:0]          chan_q;
	logic [11:0]         wic_q;
	logic [SAMPLE_W-1:0] min_q, max_q;
	logic [31:0]         held_q;
	logic [15:0]         cnt_q;

	lane_t [LANES-1:0]   lanes;
	merge_t              merged;
	logic                in_acc;
	logic                room2;
	logic [11:0]         wic_next, len;
	logic                chan_end, last_chan;
	logic [15:0]         cnt_next;
	logic [1:0]          push_n;
	res_t                res0, res1, head;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room2;
	assign in_acc    = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			wpc_q  <= 12'd1;
			mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q  <= cfg_data[8:0];
				CFG_WORDS:     wpc_q  <= cfg_data[11:0];
				CFG_FMT_MASK:  mask_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// byte lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		dzs_lane u_lane (
			.sample  (raw_word[g*SAMPLE_W +: SAMPLE_W]),
			.run_min (min_q),
			.run_max (max_q),
			.lane    (lanes[g])
		);
	end

	dzs_merge u_merge (
		.lanes     (lanes),
		.threshold (thr_q),
		.merged    (merged)
	);

	// channel end and word count
	always_comb begin
		wic_next  = wic_q + 12'd1;
		len       = (wpc_q == '0) ? 12'd1 : wpc_q;
		chan_end  = (wic_next >= len);
		last_chan = (chan_q == 3'(CHANNELS - 1));
		cnt_next  = cnt_q + (merged.keep ? {4'd0, len} : 16'd0);
	end

	// results of the current word
	always_comb begin
		res0   = '0;
		res1   = '0;
		push_n = 2'd0;
		if (hdr_pos_q != HDR_DATA) begin
			res0.out_word     = raw_word | ((hdr_pos_q == HDR_WORD1) ? mask_q : 32'd0);
			res0.word_kind    = KIND_HEADER;
			res0.header_index = hdr_pos_q[1:0];
			if (hdr_pos_q != HDR_WORD0) begin
				push_n = 2'd1;
			end
		end else begin
			res0.out_word       = {17'd0, chan_q, (merged.keep ? len : 12'd0)};
			res0.word_kind      = KIND_DESC;
			res0.channel_number = chan_q;
			res0.keep_channel   = merged.keep;
			res1.out_word       = (held_q & HDR0_KEEP_MASK) | {16'd0, cnt_next};
			res1.word_kind      = KIND_HDR0;
			res1.end_of_event   = 1'b1;
			if (chan_end) begin
				push_n = last_chan ? 2'd2 : 2'd1;
			end
		end
		if (!in_acc) begin
			push_n = 2'd0;
		end
	end

	// event sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= HDR_WORD0;
			chan_q    <= '0;
			wic_q     <= '0;
			min_q     <= '1;
			max_q     <= '0;
			held_q    <= '0;
			cnt_q     <= 16'(4 + CHANNELS);
		end else if (in_acc) begin
			if (hdr_pos_q != HDR_DATA) begin
				hdr_pos_q <= hdr_pos_q + 3'd1;
				if (hdr_pos_q == HDR_WORD0) begin
					held_q <= raw_word;
				end
			end else if (chan_end) begin
				wic_q <= '0;
				min_q <= '1;
				max_q <= '0;
				if (last_chan) begin
					hdr_pos_q <= HDR_WORD0;
					chan_q    <= '0;
					cnt_q     <= 16'(4 + CHANNELS);
				end else begin
					chan_q <= chan_q + 3'd1;
					cnt_q  <= cnt_next;
				end
			end else begin
				wic_q <= wic_next;
				min_q <= merged.min;
				max_q <= merged.max;
			end
		end
	end

	dzs_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push0      (res0),
		.push1      (res1),
		.room2      (room2),
		.head_valid (out_valid),
		.head       (head),
		.pop        (!out_stall)
	);

	assign out_word       = head.out_word;
	assign word_kind      = head.word_kind;
	assign header_index   = head.header_index;
	assign channel_number = head.channel_number;
	assign keep_channel   = head.keep_channel;
	assign end_of_event   = head.end_of_event;

	a_eoe_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_event) |-> (word_kind == KIND_HDR0))
		else $error("end of event on a word that is not header word 0");

	a_two_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (last_chan && chan_end && hdr_pos_q == HDR_DATA))
		else $error("two results from a word that does not close the event");

	a_data_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |=> (hdr_pos_q == HDR_WORD0 && chan_q == '0))
		else $error("event not closed after patched header word");

endmodule
